// ----- sv/mac_forwarding_table_assert.svh -----
// Assertion macros for the forwarding table.
// Included by the top level; no other dependencies.
`ifndef MAC_FORWARDING_TABLE_ASSERT_SVH
`define MAC_FORWARDING_TABLE_ASSERT_SVH
`ifndef SYNTH
`define MFT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("forwarding table check failed");
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("forwarding table check failed");
`else
`define MFT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/mft_pkg.sv -----
// Shared types and constants of the forwarding table.
// No dependencies; used by mft_store, mft_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mft_pkg;
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 9;

    localparam logic [2:0] OP_LEARN      = 3'd0;
    localparam logic [2:0] OP_LOOKUP     = 3'd1;
    localparam logic [2:0] OP_ADD_STATIC = 3'd2;
    localparam logic [2:0] OP_TICK       = 3'd3;
    localparam logic [2:0] OP_AGE        = 3'd4;
    localparam logic [2:0] OP_FLUSH_PORT = 3'd5;
    localparam logic [2:0] OP_FLUSH_VLAN = 3'd6;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] mac_address;
        logic [11:0] vlan_id;
        logic [7:0]  port_number;
    } t_req;

    typedef struct packed {
        logic           found;
        logic [7:0]     port_out;
        logic           learned_new;
        logic           full_error;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] live_count;
    } t_rsp;

    typedef struct packed {
        logic        pinned;
        logic [47:0] mac;
        logic [11:0] vlan;
        logic [7:0]  port;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           wdata;
    } t_mem_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- sv/mft_chan_if.sv -----
// Valid/ready channel carrying one payload beat.
// Depends on nothing; payload type is set by the user.
`timescale 1ns / 1ps
`default_nettype none
interface mft_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/mft_store.sv -----
// Single-port entry memory of the forwarding table with a registered read.
// Depends on mft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mft_store (
    input  wire logic              i_clk,
    input  wire mft_pkg::t_mem_req i_req,
    output mft_pkg::t_entry        o_rd_data
);
    import mft_pkg::*;

    t_entry mem [CAPACITY];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        r_rd_data <= mem[i_req.addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

// ----- sv/mft_ctrl.sv -----
// Operation sequencer: scans the entry memory, keeps valid bits, time and count.
// Depends on mft_pkg; drives the port of mft_store.
`timescale 1ns / 1ps
`default_nettype none
module mft_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire mft_pkg::t_req     i_req,
    input  wire logic [30:0]       i_aging_limit,
    output mft_pkg::t_mem_req      o_mem,
    input  wire mft_pkg::t_entry   i_rd_data,
    output logic                   o_res_valid,
    input  wire logic              i_res_take,
    output mft_pkg::t_rsp          o_res
);
    import mft_pkg::*;

    t_state r_state, n_state;

    logic [CAPACITY-1:0] r_valid;
    logic [CNT_W-1:0]    r_total;
    logic [31:0]         r_time;

    logic [2:0]  r_op;
    logic [47:0] r_mac;
    logic [11:0] r_vlan;
    logic [7:0]  r_port;

    logic             r_issuing;
    logic [IDX_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_hit_static;
    logic [7:0]       r_hit_port;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    logic             r_found;
    logic [7:0]       r_port_out;
    logic             r_learned;
    logic             r_full;
    logic [CNT_W-1:0] r_removed;

    logic        accept;
    logic        key_op;
    logic        slot_live;
    logic        key_match;
    logic [31:0] age;
    logic        kill;
    logic        scan_end;

    assign accept    = i_req_valid && o_req_ready;
    assign key_op    = (r_op == OP_LEARN) || (r_op == OP_LOOKUP) || (r_op == OP_ADD_STATIC);
    assign slot_live = r_valid[r_rd_idx];
    assign key_match = (i_rd_data.mac == r_mac) && (i_rd_data.vlan == r_vlan);
    assign age       = r_time - i_rd_data.stamp;
    assign scan_end  = !r_issuing && !r_rd_vld;

    always_comb begin
        unique case (r_op)
            OP_AGE:        kill = !i_rd_data.pinned && (age > {1'b0, i_aging_limit});
            OP_FLUSH_PORT: kill = (i_rd_data.port == r_port);
            OP_FLUSH_VLAN: kill = (i_rd_data.vlan == r_vlan);
            default:       kill = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.addr  = r_addr;
        o_mem.wdata = '{pinned: (r_op == OP_ADD_STATIC), mac: r_mac, vlan: r_vlan,
                        port: r_port, stamp: r_time};
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if ((i_req.operation == OP_TICK) || (i_req.operation == OP_UNUSED)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = key_op ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                // An existing key is rewritten in place; learn leaves static entries alone.
                if (r_hit) begin
                    o_mem.addr = r_hit_idx;
                    o_mem.we   = (r_op == OP_ADD_STATIC) ||
                                 ((r_op == OP_LEARN) && !r_hit_static);
                end else begin
                    o_mem.addr = r_free_idx;
                    o_mem.we   = r_free && (r_op != OP_LOOKUP);
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_total   <= '0;
            r_time    <= '0;
            r_issuing <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (i_req.operation == OP_TICK)) begin
                r_time <= r_time + 32'd1;
            end
            if (accept) begin
                r_issuing <= (i_req.operation != OP_TICK) && (i_req.operation != OP_UNUSED);
            end else if (r_issuing && (r_addr == IDX_W'(CAPACITY - 1))) begin
                r_issuing <= 1'b0;
            end
            r_rd_vld <= r_issuing;
            if (r_rd_vld && slot_live && !key_op && kill) begin
                r_valid[r_rd_idx] <= 1'b0;
                r_total           <= r_total - CNT_W'(1);
            end
            if ((r_state == ST_WRITE) && !r_hit && r_free && (r_op != OP_LOOKUP)) begin
                r_valid[r_free_idx] <= 1'b1;
                r_total             <= r_total + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_req.operation;
            r_mac        <= i_req.mac_address;
            r_vlan       <= i_req.vlan_id;
            r_port       <= i_req.port_number;
            r_addr       <= '0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
            r_found      <= 1'b0;
            r_port_out   <= '0;
            r_learned    <= 1'b0;
            r_full       <= 1'b0;
            r_removed    <= '0;
        end else if (r_issuing) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        r_rd_idx <= r_addr;
        if (r_rd_vld) begin
            if (slot_live && key_match && !r_hit) begin
                r_hit        <= 1'b1;
                r_hit_idx    <= r_rd_idx;
                r_hit_static <= i_rd_data.pinned;
                r_hit_port   <= i_rd_data.port;
            end
            if (!slot_live && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (slot_live && !key_op && kill) begin
                r_removed <= r_removed + CNT_W'(1);
            end
        end
        if (r_state == ST_WRITE) begin
            if (r_op == OP_LOOKUP) begin
                r_found    <= r_hit;
                r_port_out <= r_hit ? r_hit_port : 8'd0;
            end else begin
                r_learned <= !r_hit && r_free;
                r_full    <= !r_hit && !r_free;
            end
        end
    end

    assign o_res = '{found: r_found, port_out: r_port_out, learned_new: r_learned,
                     full_error: r_full, removed_count: r_removed, live_count: r_total};
endmodule
`default_nettype wire

// ----- sv/mac_forwarding_table.sv -----
// Layer-2 forwarding table keyed by MAC address and VLAN, 256 slots.
// Channels: i_req takes one operation per beat (learn, lookup, add static,
// tick, age sweep, flush port, flush vlan); o_rsp returns exactly one result
// beat per operation, in order. i_cfg_we/i_cfg_wdata set the aging limit and
// may be written only while the table is idle.
// Tick and the unused operation code go straight to the result. Every other
// operation reads all 256 slots through the single port of the entry memory,
// one slot a cycle; learn, lookup and add static then pass through a write
// state. One operation is in work at a time, so a new operation is taken
// only after the last one has handed its result on.
// A finished result sits in the output register; while the receiver stalls,
// the next operation is already accepted and worked on, and its result waits
// until the register is free.
// Reset clears all valid bits, the entry count and the tick counter, and sets
// the aging limit to 300. No clearing pass is needed; the block is ready in
// the cycle after reset.
// Depends on mft_pkg, mft_chan_if, mft_store, mft_ctrl and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "mac_forwarding_table_assert.svh"
module mac_forwarding_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mft_chan_if.sink   i_req,
    mft_chan_if.source o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_wdata
);
    import mft_pkg::*;

    logic [30:0] r_aging_limit;
    logic        r_out_valid;
    t_rsp        r_out;

    t_mem_req mem_req;
    t_entry   rd_data;
    logic     res_valid;
    logic     res_take;
    t_rsp     res;

    assign res_take = !r_out_valid || o_rsp.ready;

    mft_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    mft_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_req         (i_req.payload),
        .i_aging_limit (r_aging_limit),
        .o_mem         (mem_req),
        .i_rd_data     (rd_data),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging_limit <= 31'd300;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_aging_limit <= i_cfg_wdata;
            end
            if (res_valid && res_take) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // The sequencer holds one operation at a time.
    `MFT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
                     i_req.valid && i_req.ready, !i_req.ready)
    `MFT_ASSERT_SAME(a_full_means_all_used, i_clk, i_rst_n,
                     o_rsp.valid && o_rsp.payload.full_error,
                     o_rsp.payload.live_count == CNT_W'(CAPACITY))
    `MFT_ASSERT_SAME(a_new_or_full, i_clk, i_rst_n, o_rsp.valid,
                     !(o_rsp.payload.learned_new && o_rsp.payload.full_error))
endmodule
`default_nettype wire
